FILE: hdl/nhs_pkg.sv
package nhs_pkg;

  // Default coordinate width of the point stream
  localparam int CoordBitsDefault = 16;

  // Configuration port geometry
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Result field widths
  localparam int DistW = 32;
  localparam int LinW  = 10;
  localparam int AngW  = 11;

  // Squared threshold width (15 bit distance squared)
  localparam int ThrSqW = 30;

  typedef enum logic [1:0] {
    CLS_SAFE = 2'd0,
    CLS_OBST = 2'd1,
    CLS_PIT  = 2'd2,
    CLS_CRIT = 2'd3
  } hz_class_e;

  typedef enum logic [1:0] {
    SIDE_FRONT = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } hz_side_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OBST_HEIGHT = 2'd0,
    CFG_PIT_DEPTH   = 2'd1,
    CFG_SAFE_DIST   = 2'd2,
    CFG_CRIT_DIST   = 2'd3
  } cfg_idx_e;

  // Per-point classification travelling with the squared coordinates
  typedef struct packed {
    hz_class_e cls;
    hz_side_e  side;
    logic      y_pos;
    logic      last;
  } pt_info_t;

  // Nearest hazard record
  typedef struct packed {
    logic [DistW-1:0] dist_sq;
    hz_class_e        cls;
    hz_side_e         side;
    logic             y_pos;
  } best_t;

  localparam best_t BestNone = '{
    dist_sq: '1,
    cls:     CLS_SAFE,
    side:    SIDE_FRONT,
    y_pos:   1'b0
  };

  // Configuration reset values
  localparam logic signed [15:0] ObstHeightRst = 16'sd650;
  localparam logic signed [15:0] PitDepthRst   = -16'sd150;
  localparam logic [14:0]        SafeDistRst   = 15'd2000;
  localparam logic [14:0]        CritDistRst   = 15'd500;
  localparam logic [ThrSqW-1:0]  SafeSqRst     = 30'd4000000;
  localparam logic [ThrSqW-1:0]  CritSqRst     = 30'd250000;

  // Steering commands
  localparam logic signed [LinW-1:0] LinCruise = 10'sd500;
  localparam logic signed [LinW-1:0] LinTurn   = 10'sd200;
  localparam logic signed [LinW-1:0] LinSlow   = 10'sd100;
  localparam logic signed [LinW-1:0] LinStop   = 10'sd0;
  localparam logic signed [AngW-1:0] AngHard   = 11'sd700;
  localparam logic signed [AngW-1:0] AngTurn   = 11'sd500;
  localparam logic signed [AngW-1:0] AngZero   = 11'sd0;

endpackage

FILE: hdl/nhs_point_if.sv
interface nhs_point_if
  import nhs_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDefault
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic                         last_point;

  modport source (output valid, pos_x, pos_y, pos_z, last_point, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_point, output ready);
endinterface

FILE: hdl/nhs_result_if.sv
interface nhs_result_if
  import nhs_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [1:0]             hazard_class;
  logic [1:0]             hazard_side;
  logic [DistW-1:0]       nearest_dist_sq;
  logic signed [LinW-1:0] linear_speed;
  logic signed [AngW-1:0] angular_rate;

  modport source (output valid, hazard_class, hazard_side, nearest_dist_sq, linear_speed,
                  angular_rate, input ready);
  modport sink   (input valid, hazard_class, hazard_side, nearest_dist_sq, linear_speed,
                  angular_rate, output ready);
endinterface

FILE: hdl/nhs_front.sv
module nhs_front
  import nhs_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic                         last_i,
  input  logic signed [15:0]           obst_height_i,
  input  logic signed [15:0]           pit_depth_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2*COORD_BITS-2:0]      sq_x_o,
  output logic [2*COORD_BITS-2:0]      sq_y_o,
  output logic [2*COORD_BITS-2:0]      sq_z_o,
  output pt_info_t                     info_o
);
  localparam int C   = COORD_BITS;
  localparam int SqW = 2 * C - 1;

  logic                s0_v_q, s0_v_d;
  logic signed [C-1:0] x_q, y_q, z_q;
  logic                last_q;
  logic                s1_v_q, s1_v_d;
  logic [SqW-1:0]      sqx_q, sqy_q, sqz_q;
  pt_info_t            info_q, info_d;

  logic                s1_free, s0_move, in_take;
  logic [C-1:0]        ax, ay, az;
  logic [2*C-1:0]      px, py, pz;
  logic signed [31:0]  z_ext, obst_ext, pit_ext;
  logic signed [C:0]   xe, ye, nxe;

  // Handshake between the input register and the square register
  assign s1_free    = !s1_v_q || out_ready_i;
  assign s0_move    = s0_v_q && s1_free;
  assign in_ready_o = !s0_v_q || s1_free;
  assign in_take    = in_valid_i && in_ready_o;
  assign s0_v_d     = in_take || (s0_v_q && !s1_free);
  assign s1_v_d     = s0_move || (s1_v_q && !out_ready_i);

  // Magnitudes and squares
  always_comb begin
    ax = x_q[C-1] ? (~x_q + 1'b1) : x_q;
    ay = y_q[C-1] ? (~y_q + 1'b1) : y_q;
    az = z_q[C-1] ? (~z_q + 1'b1) : z_q;
    px = (2*C)'(ax) * (2*C)'(ax);
    py = (2*C)'(ay) * (2*C)'(ay);
    pz = (2*C)'(az) * (2*C)'(az);
  end

  // Height class, sector and side flag
  always_comb begin
    z_ext    = {{(32-C){z_q[C-1]}}, z_q};
    obst_ext = {{16{obst_height_i[15]}}, obst_height_i};
    pit_ext  = {{16{pit_depth_i[15]}}, pit_depth_i};
    xe       = {x_q[C-1], x_q};
    ye       = {y_q[C-1], y_q};
    nxe      = -xe;

    info_d.last  = last_q;
    info_d.y_pos = (ye > 0);

    if (z_ext > obst_ext) begin
      info_d.cls = CLS_OBST;
    end else if (z_ext < pit_ext) begin
      info_d.cls = CLS_PIT;
    end else begin
      info_d.cls = CLS_SAFE;
    end

    if (xe > 0 && ye >= nxe && ye < xe) begin
      info_d.side = SIDE_FRONT;
    end else if (ye > 0 && ye >= xe && ye > nxe) begin
      info_d.side = SIDE_LEFT;
    end else if (ye < 0 && ye <= xe && ye < nxe) begin
      info_d.side = SIDE_RIGHT;
    end else begin
      info_d.side = SIDE_FRONT;
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      s0_v_q <= s0_v_d;
      s1_v_q <= s1_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      z_q    <= pos_z_i;
      last_q <= last_i;
    end
    if (s0_move) begin
      sqx_q  <= px[SqW-1:0];
      sqy_q  <= py[SqW-1:0];
      sqz_q  <= pz[SqW-1:0];
      info_q <= info_d;
    end
  end

  assign out_valid_o = s1_v_q;
  assign sq_x_o      = sqx_q;
  assign sq_y_o      = sqy_q;
  assign sq_z_o      = sqz_q;
  assign info_o      = info_q;

endmodule

FILE: hdl/nhs_track.sv
module nhs_track
  import nhs_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2*COORD_BITS-2:0] sq_x_i,
  input  logic [2*COORD_BITS-2:0] sq_y_i,
  input  logic [2*COORD_BITS-2:0] sq_z_i,
  input  pt_info_t                info_i,
  input  logic [ThrSqW-1:0]       safe_sq_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output best_t                   best_o
);
  localparam int SumW = 2 * COORD_BITS;
  localparam int CmpW = (SumW > DistW) ? SumW : DistW;

  best_t           best_q, best_d;
  best_t           fin_q;
  best_t           merged, cand;
  logic            fin_v_q, fin_v_d;
  logic            fin_free, consume, hazard;
  logic [SumW-1:0] d2;
  logic [CmpW-1:0] d2_ext, safe_ext, best_ext;

  // A closing point needs the snapshot register free; others always pass
  assign fin_free   = !fin_v_q || out_ready_i;
  assign in_ready_o = !info_i.last || fin_free;
  assign consume    = in_valid_i && in_ready_o;
  assign fin_v_d    = (consume && info_i.last) || (fin_v_q && !out_ready_i);

  // Distance, hazard test and running minimum
  always_comb begin
    d2       = SumW'(sq_x_i) + SumW'(sq_y_i) + SumW'(sq_z_i);
    d2_ext   = CmpW'(d2);
    safe_ext = CmpW'(safe_sq_i);
    best_ext = CmpW'(best_q.dist_sq);
    hazard   = (info_i.cls != CLS_SAFE) && (d2_ext < safe_ext) && (d2_ext < best_ext);

    cand.dist_sq = d2_ext[DistW-1:0];
    cand.cls     = info_i.cls;
    cand.side    = info_i.side;
    cand.y_pos   = info_i.y_pos;
    merged       = hazard ? cand : best_q;

    best_d = best_q;
    if (consume) begin
      best_d = info_i.last ? BestNone : merged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= BestNone;
      fin_v_q <= 1'b0;
    end else begin
      best_q  <= best_d;
      fin_v_q <= fin_v_d;
    end
  end

  // Snapshot of the nearest hazard at the end of a cloud
  always_ff @(posedge clk_i) begin
    if (consume && info_i.last) begin
      fin_q <= merged;
    end
  end

  assign out_valid_o = fin_v_q;
  assign best_o      = fin_q;

endmodule

FILE: hdl/nhs_cmd.sv
module nhs_cmd
  import nhs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  best_t                  best_i,
  input  logic [ThrSqW-1:0]      crit_sq_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             hazard_class_o,
  output logic [1:0]             hazard_side_o,
  output logic [DistW-1:0]       nearest_dist_sq_o,
  output logic signed [LinW-1:0] linear_speed_o,
  output logic signed [AngW-1:0] angular_rate_o
);
  logic                   o_v_q, o_v_d, load;
  hz_class_e              cls, cls_q;
  hz_side_e               side_q;
  logic [DistW-1:0]       dist_q;
  logic signed [LinW-1:0] lin, lin_q;
  logic signed [AngW-1:0] ang, ang_q;

  assign in_ready_o = !o_v_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign o_v_d      = load || (o_v_q && !out_ready_i);

  // Promote to critical and pick the steering command
  always_comb begin
    cls = best_i.cls;
    if (best_i.cls != CLS_SAFE && best_i.dist_sq < DistW'(crit_sq_i)) begin
      cls = CLS_CRIT;
    end

    lin = LinStop;
    ang = AngZero;
    unique case (cls)
      CLS_SAFE: begin
        lin = LinCruise;
        ang = AngZero;
      end
      CLS_OBST: begin
        case (best_i.side)
          SIDE_LEFT: begin
            lin = LinTurn;
            ang = AngTurn;
          end
          SIDE_RIGHT: begin
            lin = LinTurn;
            ang = -AngTurn;
          end
          default: begin
            lin = LinSlow;
            ang = best_i.y_pos ? -AngHard : AngHard;
          end
        endcase
      end
      CLS_PIT: begin
        lin = LinSlow;
        case (best_i.side)
          SIDE_LEFT:  ang = AngTurn;
          SIDE_RIGHT: ang = -AngTurn;
          default:    ang = best_i.y_pos ? AngTurn : -AngTurn;
        endcase
      end
      CLS_CRIT: begin
        lin = LinStop;
        ang = AngZero;
      end
      default: begin
        lin = LinStop;
        ang = AngZero;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else begin
      o_v_q <= o_v_d;
    end
  end

  // Hold the result until the receiver takes the beat
  always_ff @(posedge clk_i) begin
    if (load) begin
      cls_q  <= cls;
      side_q <= best_i.side;
      dist_q <= best_i.dist_sq;
      lin_q  <= lin;
      ang_q  <= ang;
    end
  end

  assign out_valid_o       = o_v_q;
  assign hazard_class_o    = cls_q;
  assign hazard_side_o     = side_q;
  assign nearest_dist_sq_o = dist_q;
  assign linear_speed_o    = lin_q;
  assign angular_rate_o    = ang_q;

endmodule

FILE: hdl/nearest_hazard_steering_unit.sv
// Nearest hazard steering unit.
// point_i takes one point beat per cycle while point_i.ready is high (pos_x, pos_y, pos_z, last_point);
// a cloud is the run of points up to and including the one flagged last.
// Each point that lies above the obstacle height or below the pit depth and
// is strictly inside the safe distance competes for nearest hazard.
// result_o carries one beat per cloud: class, sector, squared distance and
// the speed and turn command; non-last points produce no beat.
// cfg_we_i writes register cfg_idx_i (0 obstacle height, 1 pit depth,
// 2 safe distance, 3 critical distance) from cfg_data_i; write only while
// no cloud is in flight.
// The last point passes the input register, square stage, nearest-hazard
// snapshot and command stage before its result beat is valid. Throughput:
// one point per cycle unless a last point waits for room, set by the
// accumulator update.
// Reset clears the nearest-hazard record and all valid flags and restores the
// register defaults. While result_o is stalled, non-last points keep flowing;
// a last point waits for room while the snapshot and command registers are full.
module nearest_hazard_steering_unit
  import nhs_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  nhs_point_if.sink           point_i,
  nhs_result_if.source        result_o
);
  localparam int SqW = 2 * COORD_BITS - 1;

  logic signed [15:0] obst_q, pit_q;
  logic [14:0]        safe_q, crit_q;
  logic [ThrSqW-1:0]  safe_sq_q, crit_sq_q;

  logic               f_valid, f_ready;
  logic [SqW-1:0]     sq_x, sq_y, sq_z;
  pt_info_t           info;
  logic               t_valid, t_ready;
  best_t              best;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obst_q <= ObstHeightRst;
      pit_q  <= PitDepthRst;
      safe_q <= SafeDistRst;
      crit_q <= CritDistRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OBST_HEIGHT: obst_q <= cfg_data_i;
        CFG_PIT_DEPTH:   pit_q  <= cfg_data_i;
        CFG_SAFE_DIST:   safe_q <= cfg_data_i[14:0];
        CFG_CRIT_DIST:   crit_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Squared thresholds, refreshed every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_sq_q <= SafeSqRst;
      crit_sq_q <= CritSqRst;
    end else begin
      safe_sq_q <= ThrSqW'(safe_q) * ThrSqW'(safe_q);
      crit_sq_q <= ThrSqW'(crit_q) * ThrSqW'(crit_q);
    end
  end

  nhs_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (point_i.valid),
    .in_ready_o   (point_i.ready),
    .pos_x_i      (point_i.pos_x),
    .pos_y_i      (point_i.pos_y),
    .pos_z_i      (point_i.pos_z),
    .last_i       (point_i.last_point),
    .obst_height_i(obst_q),
    .pit_depth_i  (pit_q),
    .out_valid_o  (f_valid),
    .out_ready_i  (f_ready),
    .sq_x_o       (sq_x),
    .sq_y_o       (sq_y),
    .sq_z_o       (sq_z),
    .info_o       (info)
  );

  nhs_track #(
    .COORD_BITS(COORD_BITS)
  ) u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .sq_x_i     (sq_x),
    .sq_y_i     (sq_y),
    .sq_z_i     (sq_z),
    .info_i     (info),
    .safe_sq_i  (safe_sq_q),
    .out_valid_o(t_valid),
    .out_ready_i(t_ready),
    .best_o     (best)
  );

  nhs_cmd u_cmd (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (t_valid),
    .in_ready_o       (t_ready),
    .best_i           (best),
    .crit_sq_i        (crit_sq_q),
    .out_valid_o      (result_o.valid),
    .out_ready_i      (result_o.ready),
    .hazard_class_o   (result_o.hazard_class),
    .hazard_side_o    (result_o.hazard_side),
    .nearest_dist_sq_o(result_o.nearest_dist_sq),
    .linear_speed_o   (result_o.linear_speed),
    .angular_rate_o   (result_o.angular_rate)
  );

endmodule
